[design/step_command_parser_counters_assert.svh]
// Assertion helpers used by the counter back.
`ifndef STEP_COMMAND_PARSER_COUNTERS_ASSERT_SVH
`define STEP_COMMAND_PARSER_COUNTERS_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SCPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SCPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/scpc_pkg.sv]
package scpc_pkg;

    // Number of values in a MOTOR line
    localparam int NUM_VALUES = 6;
    // Widest step count supported
    localparam int CNT_W_MAX = 32;
    // Width of the reported channel count
    localparam int RES_COUNT_W = 16;
    // Width of the reported masks
    localparam int MASK_W = 6;

    // Opcodes of an input beat
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_PULSE = 1'b1;

    // Event kinds, also used as command kinds between front and back
    localparam logic [1:0] EV_BYTE   = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;
    localparam logic [1:0] EV_PULSE  = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [2:0] pulse_channel;
    } scpc_in_t;

    typedef struct packed {
        logic [1:0]                                 kind;
        logic [2:0]                                 channel;
        logic [NUM_VALUES-1:0]                      neg;
        logic [NUM_VALUES-1:0][CNT_W_MAX-1:0]       mag;
    } scpc_cmd_t;

    typedef struct packed {
        logic [1:0]             event_kind;
        logic [MASK_W-1:0]      run_mask;
        logic [MASK_W-1:0]      direction_mask;
        logic [RES_COUNT_W-1:0] channel_count;
    } scpc_res_t;

endpackage

[design/scpc_fifo.sv]
module scpc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[design/scpc_front.sv]
module scpc_front #(
    parameter int LINE_LIMIT = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  scpc_pkg::scpc_in_t  item,
    output scpc_pkg::scpc_cmd_t cmd
);

    import scpc_pkg::*;

    localparam int LEN_W = $clog2(LINE_LIMIT + 1);
    localparam int EXT_W = COUNT_BITS + 4;
    localparam logic [EXT_W-1:0] COUNT_MAX = {4'b0, {COUNT_BITS{1'b1}}};

    // Parser phases
    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_TOKEN  = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_SIGN   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [2:0] KEY_LEN   = 3'd5;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_FF     = 8'd12;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_MINUS  = 8'd45;

    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'd77;  // M
            3'd1:    c = 8'd79;  // O
            3'd2:    c = 8'd84;  // T
            3'd3:    c = 8'd79;  // O
            3'd4:    c = 8'd82;  // R
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    logic [2:0]            phase_reg, phase_next;
    logic [2:0]            tpos_reg, tpos_next;
    logic                  fail_reg, fail_next;
    logic [2:0]            vidx_reg, vidx_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [COUNT_BITS-1:0] pend_mag_reg [NUM_VALUES];
    logic                  pend_neg_reg [NUM_VALUES];

    logic                  pend_we;
    logic [7:0]            c;
    logic                  is_space;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [EXT_W-1:0]      acc_add;
    logic [COUNT_BITS-1:0] acc_sat;
    logic                  finishing;
    logic                  accept;

    assign c        = item.rx_byte;
    assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_FF);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = 4'(c - CH_ZERO);
    assign acc_add  = EXT_W'(acc_reg) * EXT_W'(10) + EXT_W'(digit);
    assign acc_sat  = (acc_add > COUNT_MAX) ? {COUNT_BITS{1'b1}} : acc_add[COUNT_BITS-1:0];

    // Classify the beat and advance the parser
    always_comb
    begin
        phase_next = phase_reg;
        tpos_next  = tpos_reg;
        fail_next  = fail_reg;
        vidx_next  = vidx_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        len_next   = len_reg;
        pend_we    = 1'b0;
        finishing  = !fail_reg && (phase_reg == PH_DIGITS);
        accept     = 1'b0;

        cmd         = '0;
        cmd.channel = item.pulse_channel;
        cmd.kind    = (item.opcode == OP_PULSE) ? EV_PULSE : EV_BYTE;
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            cmd.mag[i] = CNT_W_MAX'(pend_mag_reg[i]);
            cmd.neg[i] = pend_neg_reg[i];
        end

        if (item.opcode == OP_BYTE)
        begin
            if (c == CH_CR)
            begin
                // End of line: finish a pending number and decide
                accept = !fail_reg && ((phase_reg == PH_DONE) ||
                         (finishing && vidx_reg == 3'(NUM_VALUES - 1)));
                cmd.kind = accept ? EV_ACCEPT : EV_REJECT;
                if (finishing)
                begin
                    for (int i = 0; i < NUM_VALUES; i++)
                    begin
                        if (vidx_reg == 3'(i))
                        begin
                            cmd.mag[i] = CNT_W_MAX'(acc_reg);
                            cmd.neg[i] = neg_reg;
                        end
                    end
                end
                phase_next = PH_LEAD;
                tpos_next  = 3'd0;
                fail_next  = 1'b0;
                vidx_next  = 3'd0;
                acc_next   = '0;
                neg_next   = 1'b0;
                len_next   = '0;
            end
            else if (len_reg < LEN_W'(LINE_LIMIT))
            begin
                len_next = len_reg + LEN_W'(1);
                if (!fail_reg && phase_reg != PH_DONE)
                begin
                    if (c == CH_NUL)
                    begin
                        // NUL ends the text of the line
                        if (phase_reg == PH_DIGITS)
                        begin
                            pend_we    = 1'b1;
                            vidx_next  = vidx_reg + 3'd1;
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            phase_next = (vidx_reg == 3'(NUM_VALUES - 1)) ? PH_DONE : PH_GAP;
                        end
                        if (phase_next != PH_DONE)
                        begin
                            fail_next = 1'b1;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_LEAD:
                            begin
                                if (!is_space)
                                begin
                                    if (c == key_char(3'd0))
                                    begin
                                        tpos_next  = 3'd1;
                                        phase_next = PH_TOKEN;
                                    end
                                    else
                                    begin
                                        fail_next = 1'b1;
                                    end
                                end
                            end
                            PH_TOKEN:
                            begin
                                if (is_space)
                                begin
                                    if (tpos_reg == KEY_LEN)
                                    begin
                                        phase_next = PH_GAP;
                                    end
                                    else
                                    begin
                                        fail_next = 1'b1;
                                    end
                                end
                                else if (tpos_reg < KEY_LEN && c == key_char(tpos_reg))
                                begin
                                    tpos_next = tpos_reg + 3'd1;
                                end
                                else
                                begin
                                    fail_next = 1'b1;
                                end
                            end
                            PH_GAP:
                            begin
                                if (is_space)
                                begin
                                    phase_next = PH_GAP;
                                end
                                else if (c == CH_PLUS || c == CH_MINUS)
                                begin
                                    neg_next   = (c == CH_MINUS);
                                    phase_next = PH_SIGN;
                                end
                                else if (is_digit)
                                begin
                                    acc_next   = acc_sat;
                                    phase_next = PH_DIGITS;
                                end
                                else
                                begin
                                    fail_next = 1'b1;
                                end
                            end
                            PH_SIGN:
                            begin
                                if (is_digit)
                                begin
                                    acc_next   = acc_sat;
                                    phase_next = PH_DIGITS;
                                end
                                else
                                begin
                                    fail_next = 1'b1;
                                end
                            end
                            PH_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    acc_next = acc_sat;
                                end
                                else
                                begin
                                    // Close the number, then, unless it was the last, treat the byte as a gap byte
                                    pend_we   = 1'b1;
                                    vidx_next = vidx_reg + 3'd1;
                                    acc_next  = '0;
                                    neg_next  = 1'b0;
                                    if (vidx_reg == 3'(NUM_VALUES - 1))
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    else if (is_space)
                                    begin
                                        phase_next = PH_GAP;
                                    end
                                    else if (c == CH_PLUS || c == CH_MINUS)
                                    begin
                                        neg_next   = (c == CH_MINUS);
                                        phase_next = PH_SIGN;
                                    end
                                    else
                                    begin
                                        phase_next = PH_GAP;
                                        fail_next  = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                fail_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Hold the finished values of the line
    always_ff @(posedge clk)
    begin
        if (take && pend_we)
        begin
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                if (vidx_reg == 3'(i))
                begin
                    pend_mag_reg[i] <= acc_reg;
                    pend_neg_reg[i] <= neg_reg;
                end
            end
        end
    end

    // Update parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            tpos_reg  <= 3'd0;
            fail_reg  <= 1'b0;
            vidx_reg  <= 3'd0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            len_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            tpos_reg  <= tpos_next;
            fail_reg  <= fail_next;
            vidx_reg  <= vidx_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            len_reg   <= len_next;
        end
    end

endmodule

[design/scpc_back.sv]
module scpc_back #(
    parameter int CHANNELS   = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scpc_pkg::scpc_cmd_t cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output scpc_pkg::scpc_res_t res,
    input  logic                res_full,
    output logic                res_push
);

    import scpc_pkg::*;

    `include "step_command_parser_counters_assert.svh"

    logic [COUNT_BITS-1:0] cnt_reg  [CHANNELS];
    logic [COUNT_BITS-1:0] cnt_next [CHANNELS];
    logic [CHANNELS-1:0]   run_reg, run_next;
    logic [CHANNELS-1:0]   dir_reg, dir_next;
    logic [COUNT_BITS-1:0] pulse_cnt;
    logic [CNT_W_MAX-1:0]  pulse_wide;
    logic                  take;

    assign take     = !cmd_empty && !res_full;
    assign cmd_pop  = take;
    assign res_push = take;

    // Carry out the command at the head of the queue
    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        dir_next  = dir_reg;
        pulse_cnt = '0;
        case (cmd.kind)
            EV_ACCEPT:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    cnt_next[i] = cmd.mag[i][COUNT_BITS-1:0];
                    dir_next[i] = !(cmd.neg[i] && (|cmd.mag[i][COUNT_BITS-1:0]));
                    if (|cmd.mag[i][COUNT_BITS-1:0])
                    begin
                        run_next[i] = 1'b1;
                    end
                end
            end
            EV_PULSE:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (cmd.channel == 3'(i))
                    begin
                        if (cnt_reg[i] != '0)
                        begin
                            cnt_next[i] = cnt_reg[i] - COUNT_BITS'(1);
                        end
                        if (cnt_next[i] == '0)
                        begin
                            run_next[i] = 1'b0;
                        end
                        pulse_cnt = cnt_next[i];
                    end
                end
            end
            default:
            begin
                pulse_cnt = '0;
            end
        endcase
    end

    // Build the result beat
    assign pulse_wide         = CNT_W_MAX'(pulse_cnt);
    assign res.event_kind     = cmd.kind;
    assign res.run_mask       = MASK_W'(run_next);
    assign res.direction_mask = MASK_W'(dir_next);
    assign res.channel_count  = pulse_wide[RES_COUNT_W-1:0];

    // Commit counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            run_reg <= '1;
            dir_reg <= '0;
        end
        else if (take)
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
            dir_reg <= dir_next;
        end
    end

    `SCPC_ASSERT_NEXT(a_run_set_only_by_accept, take && cmd.kind != EV_ACCEPT,
        (run_reg & ~$past(run_reg)) == '0, "run bit set without an accepted command")
    `SCPC_ASSERT_NEXT(a_run_clear_only_by_pulse, take && cmd.kind != EV_PULSE,
        (~run_reg & $past(run_reg)) == '0, "run bit cleared without a pulse")
    `SCPC_ASSERT_NEXT(a_state_holds_when_idle, !take,
        $stable(run_reg) && $stable(dir_reg), "masks changed with no command taken")

endmodule

[design/step_command_parser_counters.sv]
// MOTOR command parser with per-channel step counters.
// Input channel (push/full): each beat is either a received byte or a
// pulse-finished event for one channel. A beat is taken when push is high
// and full is low. Bytes build a line; a carriage return closes it and the
// line loads six step counts, direction bits and run bits if it reads as
// MOTOR followed by six signed decimals.
// Result channel (empty/pop): exactly one result beat per input beat, in
// order, with the event kind, run and direction masks and, for pulses, the
// remaining count of that channel.
// The parser front turns a taken beat into a command held in a two-entry
// command queue; the counter back turns the queue head into a result held
// in a two-entry result queue, which decouples the receiver. Throughput:
// one beat per cycle while full stays low.
// Stall: when pop stays low, up to four beats are absorbed before full
// rises; nothing is dropped.
// Reset: the parser returns to line start, counts and direction bits clear,
// run bits go to all ones, and both queues empty.
module step_command_parser_counters #(
    parameter int LINE_LIMIT = 128,
    parameter int CHANNELS   = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  scpc_pkg::scpc_in_t  item,
    output logic                empty,
    input  logic                pop,
    output scpc_pkg::scpc_res_t result
);

    import scpc_pkg::*;

    scpc_cmd_t cmd_in;
    scpc_cmd_t cmd_out;
    scpc_res_t res_in;
    logic      take;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      res_full;
    logic      res_push;

    assign take = push && !full;

    // Parse and classify incoming beats
    scpc_front #(
        .LINE_LIMIT (LINE_LIMIT),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .cmd   (cmd_in)
    );

    // Hold commands between parser and counters
    scpc_fifo #(
        .WIDTH ($bits(scpc_cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    // Run the step counters
    scpc_back #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res_in),
        .res_full  (res_full),
        .res_push  (res_push)
    );

    // Hold results until the receiver pops them
    scpc_fifo #(
        .WIDTH ($bits(scpc_res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

[dv/step_command_parser_counters_test.sv]
`timescale 1ns / 1ps

module step_command_parser_counters_test;
    import scpc_pkg::*;

    localparam int LINE_LIMIT  = 128;
    localparam int CHANNELS    = 6;
    localparam int COUNT_BITS  = 16;
    localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
    localparam int KEY_LEN     = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_BEATS = 140;

    localparam logic [8*KEY_LEN-1:0] MOTOR_KEY = "MOTOR";
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_TOKEN,
        PH_GAP,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } parse_phase_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    scpc_in_t   item = '0;
    logic       empty;
    logic       pop = 1'b0;
    scpc_res_t  result;

    scpc_in_t   pending_beats[$];
    scpc_res_t  expected_results[$];
    scpc_res_t  want;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left = 0;
    int         cycle_count = 0;
    bit         failed = 1'b0;

    // Parser and counter state mirrored from the block
    parse_phase_e    phase;
    int              tok_pos;
    int              val_idx;
    int              line_len;
    bit              line_bad;
    bit              acc_neg;
    int unsigned     acc;
    logic [15:0]     pend_mag [NUM_VALUES];
    bit              pend_neg [NUM_VALUES];
    logic [15:0]     step_left [CHANNELS];
    logic [5:0]      dir_bits;
    logic [5:0]      run_bits;

    step_command_parser_counters #(
        .LINE_LIMIT(LINE_LIMIT),
        .CHANNELS(CHANNELS),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd12);
    endfunction

    function bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void restart_line();
        phase = PH_LEAD;
        tok_pos = 0;
        line_bad = 1'b0;
        val_idx = 0;
        acc = 0;
        acc_neg = 1'b0;
        line_len = 0;
    endfunction

    // Accumulate one decimal digit, saturating at the count maximum
    function void push_digit(logic [7:0] c);
        int unsigned v;
        v = acc * 10 + (c - CH_ZERO);
        acc = (v > COUNT_MAX) ? COUNT_MAX : v;
        phase = PH_DIGITS;
    endfunction

    function void close_number();
        if (val_idx < NUM_VALUES)
        begin
            pend_mag[val_idx] = acc[15:0];
            pend_neg[val_idx] = acc_neg;
        end
        val_idx++;
        acc = 0;
        acc_neg = 1'b0;
        phase = (val_idx >= NUM_VALUES) ? PH_DONE : PH_GAP;
    endfunction

    function void take_gap_char(logic [7:0] c);
        if (is_blank(c))
            phase = PH_GAP;
        else if (c == CH_PLUS || c == CH_MINUS)
        begin
            acc_neg = (c == CH_MINUS);
            phase = PH_SIGN;
        end
        else if (is_digit(c))
            push_digit(c);
        else
            line_bad = 1'b1;
    endfunction

    // Finish the text: close a number in progress, then demand six values
    function void close_text();
        if (line_bad)
            return;
        if (phase == PH_DIGITS)
            close_number();
        if (phase != PH_DONE)
            line_bad = 1'b1;
    endfunction

    function void parse_char(logic [7:0] c);
        if (line_bad || phase == PH_DONE)
            return;
        if (c == CH_NUL)
        begin
            close_text();
            return;
        end
        case (phase)
            PH_LEAD:
            begin
                if (!is_blank(c))
                begin
                    if (c == MOTOR_KEY[8*(KEY_LEN-1) +: 8])
                    begin
                        tok_pos = 1;
                        phase = PH_TOKEN;
                    end
                    else
                        line_bad = 1'b1;
                end
            end
            PH_TOKEN:
            begin
                if (is_blank(c))
                begin
                    if (tok_pos == KEY_LEN)
                        phase = PH_GAP;
                    else
                        line_bad = 1'b1;
                end
                else if (tok_pos < KEY_LEN && c == MOTOR_KEY[8*(KEY_LEN-1-tok_pos) +: 8])
                    tok_pos++;
                else
                    line_bad = 1'b1;
            end
            PH_GAP:
                take_gap_char(c);
            PH_SIGN:
            begin
                if (is_digit(c))
                    push_digit(c);
                else
                    line_bad = 1'b1;
            end
            PH_DIGITS:
            begin
                if (is_digit(c))
                    push_digit(c);
                else
                begin
                    close_number();
                    if (phase != PH_DONE)
                        take_gap_char(c);
                end
            end
            default:
                line_bad = 1'b1;
        endcase
    endfunction

    // Advance the mirrored state by one beat and return the result it causes
    function scpc_res_t predict_event(scpc_in_t it);
        scpc_res_t r;
        int ch;
        r = '0;
        if (it.opcode == OP_BYTE)
        begin
            if (it.rx_byte == CH_CR)
            begin
                close_text();
                if (!line_bad && phase == PH_DONE)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        step_left[i] = pend_mag[i];
                        dir_bits[i] = !(pend_neg[i] && pend_mag[i] != 0);
                        if (pend_mag[i] != 0)
                            run_bits[i] = 1'b1;
                    end
                    r.event_kind = EV_ACCEPT;
                end
                else
                    r.event_kind = EV_REJECT;
                restart_line();
            end
            else
            begin
                r.event_kind = EV_BYTE;
                if (line_len < LINE_LIMIT)
                begin
                    line_len++;
                    parse_char(it.rx_byte);
                end
            end
        end
        else
        begin
            r.event_kind = EV_PULSE;
            ch = int'(it.pulse_channel);
            if (ch < CHANNELS)
            begin
                if (step_left[ch] != 0)
                    step_left[ch]--;
                if (step_left[ch] == 0)
                    run_bits[ch] = 1'b0;
                r.channel_count = step_left[ch];
            end
        end
        r.run_mask = run_bits;
        r.direction_mask = dir_bits;
        return r;
    endfunction

    task automatic queue_beat(logic op, logic [7:0] b, logic [2:0] ch);
        scpc_in_t it;
        it.opcode = op;
        it.rx_byte = b;
        it.pulse_channel = ch;
        pending_beats.push_back(it);
    endtask

    // Mostly real channels, sometimes the unused ones
    function logic [2:0] pick_channel();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(0, CHANNELS-1));
    endfunction

    task automatic queue_pulses();
        logic [2:0] ch;
        ch = pick_channel();
        repeat ($urandom_range(1, 6))
            queue_beat(OP_PULSE, 8'($urandom_range(0, 255)), ch);
    endtask

    // Send a line character, now and then with pulse events slipped in ahead
    task automatic queue_text_byte(logic [7:0] b);
        if ($urandom_range(0, 7) == 0)
            queue_pulses();
        queue_beat(OP_BYTE, b, 3'($urandom_range(0, 7)));
    endtask

    function logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return 8'd9;
            1: return 8'd10;
            2: return 8'd11;
            3: return 8'd12;
            default: return CH_SPACE;
        endcase
    endfunction

    // Build one MOTOR line, well formed or broken in one of several ways
    task automatic queue_line();
        logic [7:0]  text[$];
        string       num;
        int          flavor;
        int          n_vals;
        int          bare_at;
        int          sign_sel;
        int unsigned mag;
        flavor = $urandom_range(0, 13);
        n_vals = (flavor == 11) ? $urandom_range(0, 5) : NUM_VALUES;
        bare_at = (flavor == 12) ? $urandom_range(0, NUM_VALUES-1) : NUM_VALUES;
        repeat ($urandom_range(0, 2))
            text.push_back(pick_blank());
        // pad the text near or past the line limit before the keyword
        if (flavor == 9)
            repeat (LINE_LIMIT - 8 + $urandom_range(0, 10))
                text.push_back(CH_SPACE);
        for (int k = KEY_LEN - 1; k >= 0; k--)
            text.push_back(MOTOR_KEY[8*k +: 8]);
        if (flavor != 10)
            repeat ($urandom_range(1, 2))
                text.push_back(pick_blank());
        for (int i = 0; i < n_vals; i++)
        begin
            sign_sel = $urandom_range(0, 3);
            if (i > 0 && !(sign_sel >= 2 && $urandom_range(0, 1) == 0))
                repeat ($urandom_range(1, 2))
                    text.push_back(pick_blank());
            if (sign_sel == 2)
                text.push_back(CH_PLUS);
            else if (sign_sel == 3 || i == bare_at)
                text.push_back(CH_MINUS);
            if (i == bare_at)
                text.push_back(CH_SPACE);
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mag = $urandom_range(0, 4);
                    5, 6: mag = $urandom_range(0, 300);
                    7: mag = $urandom_range(0, COUNT_MAX);
                    8: mag = COUNT_MAX + $urandom_range(0, 2000000);
                    default: mag = $urandom_range(0, 9);
                endcase
                num = $sformatf("%0d", mag);
                if ($urandom_range(0, 9) == 0)
                    num = {"00", num};
                for (int k = 0; k < num.len(); k++)
                    text.push_back(num[k]);
            end
        end
        // trailing text after the sixth value is ignored
        if ($urandom_range(0, 1) == 0)
        begin
            text.push_back(pick_blank());
            repeat ($urandom_range(0, 4))
                text.push_back(8'($urandom_range(33, 126)));
        end
        if (flavor == 7)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        if (flavor == 8)
            text.insert($urandom_range(0, text.size()), CH_NUL);
        foreach (text[k])
            queue_text_byte(text[k]);
        queue_text_byte(CH_CR);
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 12))
            queue_beat(OP_BYTE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 0)
            queue_beat(OP_BYTE, CH_CR, 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Offer the next beat at the falling edge unless idling
    always @(negedge clk)
    begin
        if (rst_n && pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            push <= 1'b1;
            item <= pending_beats[0];
        end
        else
            push <= 1'b0;
    end

    // Stall the result side at random, or hold off for a long stretch
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Record accepted beats and check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                void'(pending_beats.pop_front());
                expected_results.push_back(predict_event(item));
            end
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d run %b dir %b count %0d",
                             $time, result.event_kind, result.run_mask,
                             result.direction_mask, result.channel_count);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.event_kind !== want.event_kind
                        || result.run_mask !== want.run_mask
                        || result.direction_mask !== want.direction_mask
                        || result.channel_count !== want.channel_count)
                    begin
                        $display("%0t: mismatch expected kind %0d run %b dir %b count %0d",
                                 $time, want.event_kind, want.run_mask,
                                 want.direction_mask, want.channel_count);
                        $display("%0t:          actual   kind %0d run %b dir %b count %0d",
                                 $time, result.event_kind, result.run_mask,
                                 result.direction_mask, result.channel_count);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        string directed;
        // mirrored state after reset
        restart_line();
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            pend_mag[i] = '0;
            pend_neg[i] = 1'b0;
        end
        for (int i = 0; i < CHANNELS; i++)
            step_left[i] = '0;
        dir_bits = '0;
        run_bits = '1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: minus zero, overflow, zero counts, pulses down to zero
        directed = "\tMOTOR 3 -2 0 -0 99999 +1";
        for (int k = 0; k < directed.len(); k++)
            queue_beat(OP_BYTE, directed[k], 3'd0);
        queue_beat(OP_BYTE, CH_CR, 3'd7);
        queue_beat(OP_PULSE, 8'hFF, 3'd1);
        queue_beat(OP_PULSE, 8'h00, 3'd1);
        queue_beat(OP_PULSE, 8'hA5, 3'd2);
        queue_beat(OP_PULSE, 8'h5A, 3'd4);
        queue_beat(OP_PULSE, 8'h80, 3'd7);
        wait_drained();

        // Random phases under different idle and stall mixes
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
            endcase
            while (pending_beats.size() < PHASE_BEATS)
            begin
                case ($urandom_range(0, 9))
                    7, 8: queue_pulses();
                    9: queue_noise();
                    default: queue_line();
                endcase
            end
            // fill the block up against a stalled receiver
            if (p == 0)
                hold_left = LONG_HOLD;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (!failed && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
